/* design/sti_pkg.sv */
// Shared types and constants for the sorted table with insert and search.
package sti_pkg;

	localparam int unsigned POS_W = 5;
	localparam int unsigned VAL_W = 32;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef struct packed {
		logic                    req_type;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             dropped;
		logic [POS_W-1:0] fill_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_WR,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic ins_wr;
		logic probe;
	} cmd_t;

	typedef struct packed {
		logic probe_done;
	} status_t;

endpackage

/* design/sorted_table_insert_search.sv */
// Sorted table of signed values with ordered insert and binary search.
// Insert: accept, a compare step, then a shift step; the result is registered from the shift step.
// Search: a midpoint probe per step, plus an empty-range step on a miss;
// the result strobes in the cycle after the last probe.
// A new request is taken in the cycle the result strobes; results cannot be stalled.
// Reset clears the fill count and the controller; entry contents are left as they are.
module sorted_table_insert_search
	import sti_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output rsp_t result,
	output logic result_valid
);

	cmd_t    cmd;
	status_t status;

	sti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	sti_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted request did not make the block busy.");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("Result strobed while the block was still busy.");

	a_found_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.found && result.dropped))
		else $error("Result reports both found and dropped.");

	a_dropped_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dropped |-> result.fill_count == POS_W'(DEPTH))
		else $error("Dropped entry reported while the table was not full.");
`endif

endmodule

/* design/sti_ctrl.sv */
// Controller state machine that sequences insert and search requests.
module sti_ctrl
	import sti_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    req_type,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req_type == REQ_SEARCH) ? ST_PROBE : ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				state_d = ST_IDLE;
			end
			ST_PROBE: begin
				if (status.probe_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
			end
			ST_WR: begin
				cmd.ins_wr = 1'b1;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* design/sti_datapath.sv */
// Datapath with the ordered entry registers, the insert shifter and the search probe.
module sti_datapath
	import sti_pkg::*;
#(
	parameter int unsigned DEPTH = 16
)
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  req_t    req,
	output status_t status,
	output rsp_t    result,
	output logic    result_valid
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic signed [VAL_W-1:0] entries_q [DEPTH];
	logic signed [VAL_W-1:0] new_entries [DEPTH];
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] probe_e;
	logic [CW-1:0]           occ_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hx_q;
	logic [CW-1:0]           mid;
	logic [CW-1:0]           idx;
	logic [DEPTH-1:0]        lt_d;
	logic [DEPTH-1:0]        lt_q;
	logic                    full;
	logic                    ins_ok;
	logic                    range_empty;
	logic                    hit;
	rsp_t                    result_q;
	logic                    valid_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			lt_d[i] = (CW'(i) < occ_q) && (entries_q[i] < value_q);
		end
	end

	always_comb begin
		idx = DEPTH_C;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!lt_q[i]) begin
				idx = CW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (lt_q[i]) begin
				new_entries[i] = entries_q[i];
			end else if (i == 0) begin
				new_entries[i] = value_q;
			end else if (lt_q[i-1]) begin
				new_entries[i] = value_q;
			end else begin
				new_entries[i] = entries_q[i-1];
			end
		end
	end

	assign full        = (occ_q == DEPTH_C);
	assign ins_ok      = !(full && lt_q[DEPTH-1]);
	assign mid         = lo_q + ((hx_q - lo_q - CW'(1)) >> 1);
	assign probe_e     = entries_q[mid[AW-1:0]];
	assign range_empty = (lo_q >= hx_q);
	assign hit         = !range_empty && (probe_e == value_q);

	assign status.probe_done = range_empty || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.ins_wr || (cmd.probe && status.probe_done);
			if (cmd.ins_wr && !full) begin
				occ_q <= occ_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= req.value;
			lo_q    <= '0;
			hx_q    <= occ_q;
		end
		if (cmd.cmp) begin
			lt_q <= lt_d;
		end
		if (cmd.ins_wr) begin
			if (ins_ok) begin
				for (int i = 0; i < DEPTH; i++) begin
					entries_q[i] <= new_entries[i];
				end
			end
			result_q.found      <= 1'b0;
			result_q.position   <= POS_W'(ins_ok ? idx : DEPTH_C);
			result_q.dropped    <= full;
			result_q.fill_count <= POS_W'(full ? occ_q : occ_q + CW'(1));
		end
		if (cmd.probe) begin
			if (status.probe_done) begin
				result_q.found      <= hit;
				result_q.position   <= POS_W'(hit ? mid : DEPTH_C);
				result_q.dropped    <= 1'b0;
				result_q.fill_count <= POS_W'(occ_q);
			end else if (value_q < probe_e) begin
				hx_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule

/* tb/sv/testbench.sv */
// Testbench for the sorted table: directed and random requests checked against a predictor.
module testbench
	import sti_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 16;
	localparam int STALL_LIMIT = 500;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 1925;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	rsp_t result;
	logic result_valid;

	logic signed [VAL_W-1:0] model_vals [DEPTH];
	int model_fill;
	rsp_t expected_outcomes [$];
	int error_count;
	int quiet_cycles;
	int burst_left;

	sorted_table_insert_search #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result(result),
		.result_valid(result_valid)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		logic signed [VAL_W-1:0] v;
		int idx;
		int lo;
		int hi;
		int mid;
		int i;
		bit hit;
		o = '0;
		o.position = POS_W'(DEPTH);
		v = r.value;
		if (r.req_type == REQ_INSERT) begin
			idx = 0;
			while (idx < model_fill && model_vals[idx] < v)
				idx++;
			if (model_fill >= DEPTH) begin
				o.dropped = 1'b1;
				if (idx < DEPTH) begin
					for (i = DEPTH - 1; i > idx; i--)
						model_vals[i] = model_vals[i-1];
					model_vals[idx] = v;
					o.position = POS_W'(idx);
				end
			end else begin
				for (i = model_fill; i > idx; i--)
					model_vals[i] = model_vals[i-1];
				model_vals[idx] = v;
				model_fill++;
				o.position = POS_W'(idx);
			end
		end else begin
			lo = 0;
			hi = model_fill - 1;
			hit = 1'b0;
			while (!hit && lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (model_vals[mid] == v) begin
					hit = 1'b1;
					o.found = 1'b1;
					o.position = POS_W'(mid);
				end else if (v < model_vals[mid]) begin
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
		end
		o.fill_count = POS_W'(model_fill);
		return o;
	endfunction

	task automatic send_request(input logic kind, input logic signed [VAL_W-1:0] v);
		req_t r;
		int gap;
		r.req_type = kind;
		r.value = v;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		burst_left--;
		expected_outcomes.push_back(apply_request(r));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		burst_left = 0;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		logic signed [VAL_W-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: if (model_fill > 0)
				v = model_vals[$urandom_range(0, model_fill - 1)];
			2: if (model_fill > 0)
				v = model_vals[$urandom_range(0, model_fill - 1)]
					+ $signed($urandom_range(0, 2)) - 1;
			3: v = $signed($urandom_range(0, 16)) - 8;
			default: v = ($urandom_range(0, 1) == 0) ? VAL_MIN + $signed($urandom_range(0, 40))
				: VAL_MAX - $signed($urandom_range(0, 3));
		endcase
		return v;
	endfunction

	task automatic report_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (result_valid) begin
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result);
				error_count++;
			end else begin
				want = expected_outcomes.pop_front();
				report_field("found", want.found, result.found);
				report_field("position", want.position, result.position);
				report_field("dropped", want.dropped, result.dropped);
				report_field("fill_count", want.fill_count, result.fill_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("** sorted_table_insert_search: FAILED **");
				$finish;
			end
		end
	end

	task automatic test_empty_search();
		send_request(REQ_SEARCH, 0);
		send_request(REQ_SEARCH, VAL_MIN);
		send_request(REQ_SEARCH, VAL_MAX);
	endtask

	task automatic test_ordered_fill();
		logic signed [VAL_W-1:0] vals [16];
		vals = '{5, VAL_MAX, VAL_MIN, 0, -1, 5, 5, 100, -100, 7, 3, 2, 1, 9, 10, 11};
		foreach (vals[k])
			send_request(REQ_INSERT, vals[k]);
	endtask

	task automatic test_full_table();
		send_request(REQ_INSERT, -2);
		send_request(REQ_INSERT, VAL_MAX);
		send_request(REQ_INSERT, 100);
	endtask

	task automatic test_search_hits();
		send_request(REQ_SEARCH, 5);
		send_request(REQ_SEARCH, VAL_MIN);
		send_request(REQ_SEARCH, 4);
	endtask

	task automatic test_random_traffic();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 300 == 299)
				wait_drained();
			send_request($urandom_range(0, 1) ? REQ_SEARCH : REQ_INSERT, pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		model_fill = 0;
		error_count = 0;
		quiet_cycles = 0;
		burst_left = 0;
		foreach (model_vals[k])
			model_vals[k] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_search();
		test_ordered_fill();
		test_full_table();
		test_search_hits();
		wait_drained();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0)
			$display("** sorted_table_insert_search: PASSED **");
		else
			$display("** sorted_table_insert_search: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
design/sti_pkg.sv
design/sti_ctrl.sv
design/sti_datapath.sv
design/sorted_table_insert_search.sv
tb/sv/testbench.sv
